@@ rtl/core/i2cee_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants of the I2C EEPROM slave model.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_ADDR  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    localparam logic [6:0] SLAVE_ADDR_RST = 7'h50;

endpackage

@@ rtl/core/i2cee_if.sv @@
// ----------------------------------------------------------------------------
// i2cee_in_if / i2cee_out_if
// Valid/ready channels for bus event beats and result beats.
// ----------------------------------------------------------------------------
interface i2cee_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] bus_byte;

    modport source (output valid, output operation, output bus_byte, input ready);
    modport sink   (input valid, input operation, input bus_byte, output ready);
endinterface

interface i2cee_out_if;
    logic       valid;
    logic       ready;
    logic       acknowledged;
    logic [7:0] read_data;
    logic       read_valid;
    logic       bus_busy;

    modport source (output valid, output acknowledged, output read_data,
                    output read_valid, output bus_busy, input ready);
    modport sink   (input valid, input acknowledged, input read_data,
                    input read_valid, input bus_busy, output ready);
endinterface

@@ rtl/core/i2cee_mem.sv @@
// ----------------------------------------------------------------------------
// i2cee_mem
// Byte store with one write and one registered read port; per-entry valid
// bits cleared by reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module i2cee_mem #(
    parameter int MEM_BYTES = 64,
    parameter int AW        = $clog2(MEM_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0]           r_mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_vld;
    logic [7:0]           r_q;
    logic                 r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_q_vld ? r_q : 8'h00;

endmodule

@@ rtl/core/i2c_eeprom_slave_model.sv @@
// Result: each accepted event beat gives a registered result beat in the next cycle.
// Throughput: one event beat per cycle; a waiting result holds off the next
// beat until the result beat leaves, which may be in the same cycle.
// Reset: synchronous, active low; clears phase, pointer, pointer mark and
// slave address (0x50) and all memory valid bits at once, so no clearing pass.
// ----------------------------------------------------------------------------
// i2c_eeprom_slave_model
// Byte-addressable EEPROM slave driven by one I2C bus event per beat.
// ----------------------------------------------------------------------------
module i2c_eeprom_slave_model
    import i2cee_pkg::*;
#(
    parameter int MEM_BYTES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [6:0]      i_cfg_wdata,
    i2cee_in_if.sink        i_in,
    i2cee_out_if.source     o_out
);

    localparam int AW    = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int RECIP = (1 << 16) / MEM_BYTES;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_XFER = 2'd2
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [AW-1:0] r_ptr, n_ptr;
    logic          r_latched, n_latched;
    logic          r_is_read, n_is_read;
    logic [6:0]    r_slave_addr;
    logic          r_ovalid;
    logic          r_ack, n_ack;
    logic          r_rvalid, n_rvalid;
    logic          r_busy;

    logic          accept;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    logic [AW-1:0] ptr_inc;
    logic [23:0]   mod_prod;
    logic [15:0]   mod_rem;
    logic [AW-1:0] byte_ptr;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign ptr_inc = (r_ptr == AW'(MEM_BYTES - 1)) ? '0 : r_ptr + 1'b1;

    // byte modulo memory size
    always_comb begin
        mod_prod = 24'(i_in.bus_byte) * 24'(RECIP);
        mod_rem  = 16'(i_in.bus_byte) - 16'(mod_prod[23:16]) * 16'(MEM_BYTES);
        if (mod_rem >= 16'(MEM_BYTES)) begin
            mod_rem = mod_rem - 16'(MEM_BYTES);
        end
        byte_ptr = AW'(mod_rem);
    end

    always_comb begin
        n_phase   = r_phase;
        n_ptr     = r_ptr;
        n_latched = r_latched;
        n_is_read = r_is_read;
        n_ack     = 1'b0;
        n_rvalid  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        case (t_op'(i_in.operation))
            OP_START: begin
                n_phase = PH_ADDR;
            end
            OP_STOP: begin
                n_phase   = PH_IDLE;
                n_latched = 1'b0;
            end
            OP_ADDR: begin
                if (r_phase == PH_ADDR && i_in.bus_byte[7:1] == r_slave_addr) begin
                    n_is_read = i_in.bus_byte[0];
                    n_phase   = PH_XFER;
                    n_ack     = 1'b1;
                    if (i_in.bus_byte[0]) begin
                        mem_re   = 1'b1;
                        n_rvalid = 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                if (r_phase == PH_XFER && !r_is_read) begin
                    if (!r_latched) begin
                        n_ptr     = byte_ptr;
                        n_latched = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_ptr  = ptr_inc;
                    end
                    n_ack = 1'b1;
                end
            end
            OP_READ: begin
                if (r_phase == PH_XFER && r_is_read) begin
                    n_ptr     = ptr_inc;
                    mem_raddr = ptr_inc;
                    mem_re    = 1'b1;
                    n_rvalid  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_ptr        <= '0;
            r_latched    <= 1'b0;
            r_is_read    <= 1'b0;
            r_slave_addr <= SLAVE_ADDR_RST;
            r_ovalid     <= 1'b0;
            r_ack        <= 1'b0;
            r_rvalid     <= 1'b0;
            r_busy       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slave_addr <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_ptr     <= n_ptr;
                r_latched <= n_latched;
                r_is_read <= n_is_read;
                r_ack     <= n_ack;
                r_rvalid  <= n_rvalid;
                r_busy    <= (n_phase != PH_IDLE);
                r_ovalid  <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    i2cee_mem #(
        .MEM_BYTES (MEM_BYTES),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && mem_we),
        .i_waddr (r_ptr),
        .i_wdata (i_in.bus_byte),
        .i_re    (accept && mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out.valid        = r_ovalid;
    assign o_out.acknowledged = r_ack;
    assign o_out.read_valid   = r_rvalid;
    assign o_out.read_data    = r_rvalid ? mem_rdata : 8'h00;
    assign o_out.bus_busy     = r_busy;

endmodule
